@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

@@ src/tdss_pkg.sv @@
// ----------------------------------------------------------------------------
// Seven-segment scanner package
// Types, constants and decode functions of the three-digit display scanner.
// ----------------------------------------------------------------------------
package tdss_pkg;

  // Request kinds carried in tuser.
  typedef enum logic [1:0] {
    KindValue       = 2'd0,
    KindTick        = 2'd1,
    KindSetPoint    = 2'd2,
    KindTogglePoint = 2'd3
  } kind_e;

  // Scale of the incoming reading.
  localparam int unsigned Scale = 100;

  // Field widths.
  localparam int unsigned ReadingW = 21;
  localparam int unsigned PosW     = 3;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned SegW     = 7;
  localparam int unsigned ValueW   = 10;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  // Range limits of the magnitude.
  localparam int unsigned LimitTop  = 1000 * Scale;
  localparam int unsigned LimitHigh = 100 * Scale;
  localparam int unsigned LimitMid  = 10 * Scale;

  // Bits needed for any magnitude that is shown.
  localparam int unsigned MagW = $clog2(LimitTop);

  // Reciprocal multipliers: n = (mag * recip) >> RecipShift is exact because
  // 2^RecipShift exceeds the largest magnitude times Scale.
  localparam int unsigned RecipShift = $clog2(1000 * Scale * Scale + 1);
  localparam longint unsigned RecipOne =
    ((64'd1 << RecipShift) + Scale - 1) / Scale;
  localparam longint unsigned RecipTen =
    ((64'd10 << RecipShift) + Scale - 1) / Scale;
  localparam longint unsigned RecipHundred =
    ((64'd100 << RecipShift) + Scale - 1) / Scale;
  localparam int unsigned RecipW = $clog2(RecipHundred + 1);
  localparam int unsigned ProdW  = MagW + RecipW;

  // Digit codes and point positions.
  localparam logic [CodeW-1:0] BlankCode  = 4'hF;
  localparam logic [CodeW-1:0] DigitCount = 4'd10;
  localparam logic [PosW-1:0]  PointNone  = 3'b111;
  localparam logic [PosW-1:0]  PointReset = 3'd1;
  localparam logic [PosW-1:0]  PointUnits = 3'd0;
  localparam logic [PosW-1:0]  PointTens  = 3'd1;
  localparam logic [PosW-1:0]  PointHund  = 3'd2;
  localparam logic [IdxW-1:0]  LastIdx    = 2'd2;

  // Segment pattern of one digit code; codes above nine show nothing.
  function automatic logic [SegW-1:0] seg_decode(logic [CodeW-1:0] code);
    logic [SegW-1:0] segs;
    case (code)
      4'd0:    segs = 7'h3F;
      4'd1:    segs = 7'h06;
      4'd2:    segs = 7'h5B;
      4'd3:    segs = 7'h4F;
      4'd4:    segs = 7'h66;
      4'd5:    segs = 7'h6D;
      4'd6:    segs = 7'h7D;
      4'd7:    segs = 7'h07;
      4'd8:    segs = 7'h7F;
      4'd9:    segs = 7'h6F;
      default: segs = '0;
    endcase
    return segs;
  endfunction

endpackage

@@ src/three_digit_seven_segment_scanner.sv @@
// Path: a tick request passes the input register, then the output register, to the master side.
// Throughput: one request per cycle; the master side stalls the input only when a tick
// result cannot leave the output register.
// Reset: display shows blank, 0, 0 with the point on the middle digit and the scan at 0.
// ----------------------------------------------------------------------------
// Three-digit seven-segment scanner
// Converts scaled readings into three decimal digits with a decimal point and
// emits the segment pattern of the scanned digit on each scan tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_digit_seven_segment_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side: tdata = reading[20:0], lit[21], point_position[24:22], zero fill.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,
  // tuser = kind[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  // Master side: tdata = segments[6:0], point_on[7], digit_select[9:8], zero fill.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o
);
  import tdss_pkg::*;

  // Input register.
  logic                       in_valid_q;
  kind_e                      in_kind_q;
  logic signed [ReadingW-1:0] in_reading_q;
  logic                       in_lit_q;
  logic [PosW-1:0]            in_pos_q;

  // Output register.
  logic                       out_valid_q;
  logic [SegW-1:0]            out_segments_q;
  logic                       out_point_q;
  logic [IdxW-1:0]            out_digit_q;

  // Display state.
  logic [ValueW-1:0] value_q, value_d;
  logic [PosW-1:0]   point_q, point_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              phase_q, phase_d;
  logic [PosW-1:0]   saved_q, saved_d;

  logic in_go;
  logic is_tick;
  logic out_free;
  logic item_go;
  logic tick_go;

  // Handshake: an item leaves the input register unless it is a tick facing a full output.
  assign in_go    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_tick  = (in_kind_q == KindTick);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign item_go  = in_valid_q && (!is_tick || out_free);
  assign tick_go  = item_go && is_tick;
  assign s_axis_tready_o = !in_valid_q || item_go;

  // Input register load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_go) begin
      in_valid_q <= 1'b1;
    end else if (item_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      in_kind_q    <= kind_e'(s_axis_tuser_i);
      in_reading_q <= s_axis_tdata_i[ReadingW-1:0];
      in_lit_q     <= s_axis_tdata_i[ReadingW];
      in_pos_q     <= s_axis_tdata_i[ReadingW+PosW:ReadingW+1];
    end
  end

  // Magnitude, range and scaled value of a new reading.
  logic [ReadingW-1:0] mag_full;
  logic [MagW-1:0]     mag;
  logic                too_big;
  logic [RecipW-1:0]   recip;
  logic [PosW-1:0]     range_point;
  logic [ProdW-1:0]    prod;
  logic [ValueW-1:0]   value_new;

  always_comb begin
    mag_full = in_reading_q[ReadingW-1] ? (~in_reading_q + 1'b1) : in_reading_q;
    mag      = mag_full[MagW-1:0];
    too_big  = (mag_full >= ReadingW'(LimitTop));
    if (mag_full >= ReadingW'(LimitHigh)) begin
      recip       = RecipW'(RecipOne);
      range_point = PointHund;
    end else if (mag_full >= ReadingW'(LimitMid)) begin
      recip       = RecipW'(RecipTen);
      range_point = PointTens;
    end else begin
      recip       = RecipW'(RecipHundred);
      range_point = PointUnits;
    end
    prod      = ProdW'(mag) * ProdW'(recip);
    value_new = prod[RecipShift+ValueW-1:RecipShift];
  end

  // Digit split of the stored three-digit value.
  logic [CodeW-1:0]  hund;
  logic [ValueW-1:0] rem_wide;
  logic [6:0]        rem;
  logic [CodeW-1:0]  tens;
  logic [6:0]        units_wide;
  logic [CodeW-1:0]  units;

  always_comb begin
    hund = '0;
    for (int k = 1; k < 10; k++) begin
      if (value_q >= ValueW'(100 * k)) begin
        hund = CodeW'(k);
      end
    end
    rem_wide = value_q - ValueW'(hund) * ValueW'(100);
    rem      = rem_wide[6:0];
    tens = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 7'(10 * k)) begin
        tens = CodeW'(k);
      end
    end
    units_wide = rem - 7'(tens) * 7'd10;
    units      = units_wide[CodeW-1:0];
  end

  // Symbol of the scanned digit.
  logic [CodeW-1:0] code;
  logic [SegW-1:0]  tick_segs;
  logic             tick_point;

  always_comb begin
    case (scan_q)
      2'd0:    code = (value_q < ValueW'(100)) ? BlankCode : hund;
      2'd1:    code = tens;
      2'd2:    code = units;
      default: code = BlankCode;
    endcase
    if (!in_lit_q) begin
      code = BlankCode;
    end
    tick_segs  = seg_decode(code);
    tick_point = (code < DigitCount) && (point_q == {1'b0, scan_q});
  end

  // Next display state.
  always_comb begin
    value_d = value_q;
    point_d = point_q;
    scan_d  = scan_q;
    phase_d = phase_q;
    saved_d = saved_q;
    if (item_go) begin
      case (in_kind_q)
        KindValue: begin
          if (!too_big) begin
            value_d = value_new;
            point_d = range_point;
          end
        end
        KindTick: begin
          if (in_lit_q) begin
            scan_d = (scan_q == LastIdx) ? '0 : scan_q + 1'b1;
          end
        end
        KindSetPoint: begin
          point_d = in_pos_q;
        end
        KindTogglePoint: begin
          if (!phase_q) begin
            saved_d = point_q;
            point_d = PointNone;
            phase_d = 1'b1;
          end else begin
            point_d = (in_pos_q == PointNone) ? saved_q : in_pos_q;
            phase_d = 1'b0;
          end
        end
        default: begin
          value_d = value_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      point_q <= PointReset;
      scan_q  <= '0;
      phase_q <= 1'b0;
      saved_q <= '0;
    end else begin
      value_q <= value_d;
      point_q <= point_d;
      scan_q  <= scan_d;
      phase_q <= phase_d;
      saved_q <= saved_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_go) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      out_segments_q <= tick_segs;
      out_point_q    <= tick_point;
      out_digit_q    <= scan_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - SegW - 1 - IdxW)'(0), out_digit_q, out_point_q,
                            out_segments_q};

  // Checks on the scan and result bookkeeping.
  `ASSERT_CLK(a_scan_range, scan_q != 2'd3, "scan index left the digit range")
  `ASSERT_CLK(a_value_range, value_q < ValueW'(1000), "stored value exceeds three digits")
  `ASSERT_CLK(a_tick_result, tick_go |=> m_axis_tvalid_o, "tick produced no result")
  `ASSERT_CLK(a_result_source, $rose(out_valid_q) |-> $past(tick_go), "result without tick")
  `ASSERT_NEVER(a_point_blank, out_valid_q && out_point_q && (out_segments_q == '0),
    "decimal point lit on a blank digit")

endmodule

@@ verif/three_digit_seven_segment_scanner_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment scanner testbench
// Streams value, tick and decimal-point requests into the scanner with random
// gaps and output stalls. A behavioral model of the display predicts every
// scan result, and each result is checked field by field as it leaves.
// ----------------------------------------------------------------------------
module three_digit_seven_segment_scanner_tb;
  import tdss_pkg::*;

  // Segment glyphs for digits zero to nine.
  localparam logic [SegW-1:0] GlyphRom [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct {
    kind_e             kind;
    logic [ReadingW-1:0] reading;
    logic              lit;
    logic [PosW-1:0]   pos;
    int unsigned       gap;
  } scan_req_t;

  // Same layout as the low bits of the master tdata.
  typedef struct packed {
    logic [IdxW-1:0] sel;
    logic            dot;
    logic [SegW-1:0] segs;
  } pattern_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // tdata = reading[20:0], lit[21], point_position[24:22], zero fill.
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  // tuser = kind[1:0].
  logic [1:0]          s_axis_tuser_i = KindValue;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // tdata = segments[6:0], point_on[7], digit_select[9:8], zero fill.
  logic [OutDataW-1:0] m_axis_tdata_o;

  three_digit_seven_segment_scanner u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  scan_req_t   request_q [$];
  pattern_t    shown_q [$];
  int unsigned accepted_cnt = 0;
  int unsigned error_cnt    = 0;
  int unsigned idle_left    = 0;
  int unsigned stall_left   = 0;
  bit          src_calm     = 1'b0;
  bit          sink_calm    = 1'b0;
  bit          in_fire      = 1'b0;
  bit          out_fire     = 1'b0;

  // Display state as the model tracks it.
  logic [CodeW-1:0] disp_digit [3];
  logic [PosW-1:0]  disp_point;
  logic [IdxW-1:0]  disp_scan;
  logic             toggle_armed;
  logic [PosW-1:0]  held_point;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Applies one accepted request to the display state and queues the
  // pattern that a scan tick shows.
  task automatic advance_display(input scan_req_t r);
    int unsigned mag;
    int unsigned num;
    logic [IdxW-1:0]  idx;
    logic [CodeW-1:0] code;
    pattern_t         pat;
    case (r.kind)
      KindValue: begin
        mag = r.reading[ReadingW-1] ? ((32'd1 << ReadingW) - 32'(r.reading))
                                    : 32'(r.reading);
        // Magnitudes of a thousand scale units or more are dropped.
        if (mag < LimitTop) begin
          if (mag >= LimitHigh) begin
            disp_point = PointHund;
            num = mag / Scale;
          end else if (mag >= LimitMid) begin
            disp_point = PointTens;
            num = (mag * 10) / Scale;
          end else begin
            disp_point = PointUnits;
            num = (mag * 100) / Scale;
          end
          disp_digit[0] = (num >= 100) ? CodeW'((num / 100) % 10) : BlankCode;
          num = num % 100;
          disp_digit[1] = CodeW'(num / 10);
          disp_digit[2] = CodeW'(num % 10);
        end
      end
      KindSetPoint: disp_point = r.pos;
      KindTogglePoint: begin
        if (!toggle_armed) begin
          held_point   = disp_point;
          disp_point   = PointNone;
          toggle_armed = 1'b1;
        end else begin
          disp_point   = (r.pos == PointNone) ? held_point : r.pos;
          toggle_armed = 1'b0;
        end
      end
      default: begin
        idx  = IdxW'(disp_scan % 3);
        code = r.lit ? disp_digit[idx] : BlankCode;
        pat.sel  = idx;
        pat.segs = (code < DigitCount) ? GlyphRom[code] : '0;
        pat.dot  = (code < DigitCount) && (disp_point == PosW'(idx));
        shown_q.push_back(pat);
        if (r.lit) disp_scan = (idx == LastIdx) ? '0 : idx + 1'b1;
      end
    endcase
  endtask

  // Queues a request; fields that its kind ignores carry random noise.
  task automatic push_request(input kind_e k, input logic [ReadingW-1:0] rd,
                              input logic lt, input logic [PosW-1:0] ps);
    scan_req_t r;
    r.kind    = k;
    r.reading = (k == KindValue) ? rd : ReadingW'($urandom);
    r.lit     = (k == KindTick) ? lt : 1'($urandom);
    r.pos     = (k == KindSetPoint || k == KindTogglePoint) ? ps : PosW'($urandom);
    if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
    r.gap = src_calm ? 0 : $urandom_range(0, 4);
    request_q.push_back(r);
  endtask

  // Readings spread over the three point ranges, their edges, the range that
  // is dropped, and raw 21-bit patterns.
  function automatic logic [ReadingW-1:0] pick_reading();
    int unsigned mag;
    int unsigned pick;
    pick = $urandom_range(0, 11);
    case (pick)
      0, 1:    mag = $urandom_range(0, LimitMid - 1);
      2, 3:    mag = $urandom_range(LimitMid, LimitHigh - 1);
      4, 5, 6: mag = $urandom_range(LimitHigh, LimitTop - 1);
      7: begin
        case ($urandom_range(0, 7))
          0: mag = 0;
          1: mag = LimitMid - 1;
          2: mag = LimitMid;
          3: mag = LimitHigh - 1;
          4: mag = LimitHigh;
          5: mag = LimitTop - 1;
          6: mag = LimitTop;
          default: mag = 32'd1 << (ReadingW - 1);
        endcase
      end
      8:       mag = $urandom_range(LimitTop, 32'd1 << (ReadingW - 1));
      default: return ReadingW'($urandom);
    endcase
    return ReadingW'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  // Source: presents the next request once the previous one was taken.
  always @(negedge clk_i) begin
    scan_req_t req;
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      if (request_q.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        req = request_q.pop_front();
        s_axis_tdata_i  <= {{(InDataW - ReadingW - 1 - PosW){1'b0}},
                            req.pos, req.lit, req.reading};
        s_axis_tuser_i  <= req.kind;
        s_axis_tvalid_i <= 1'b1;
        if (request_q.size() > 0) idle_left = request_q[0].gap;
      end
    end
  end

  // Sink: stalls a random number of cycles after each result.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        stall_left = sink_calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Checks leaving results against the oldest prediction, then feeds the
  // accepted request to the model.
  always @(posedge clk_i) begin
    scan_req_t req;
    pattern_t  got;
    pattern_t  want;
    in_fire  = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    out_fire = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (out_fire) begin
      got = m_axis_tdata_o[SegW+IdxW:0];
      if (shown_q.size() == 0) begin
        $display("%0t: result with none predicted: expected nothing, actual %h",
                 $time, got);
        error_cnt++;
      end else begin
        want = shown_q.pop_front();
        if (got.segs !== want.segs) begin
          $display("%0t: segments expected %h actual %h", $time, want.segs, got.segs);
          error_cnt++;
        end
        if (got.dot !== want.dot) begin
          $display("%0t: point_on expected %b actual %b", $time, want.dot, got.dot);
          error_cnt++;
        end
        if (got.sel !== want.sel) begin
          $display("%0t: digit_select expected %0d actual %0d", $time, want.sel, got.sel);
          error_cnt++;
        end
      end
    end
    if (in_fire) begin
      req.kind    = kind_e'(s_axis_tuser_i);
      req.reading = s_axis_tdata_i[ReadingW-1:0];
      req.lit     = s_axis_tdata_i[ReadingW];
      req.pos     = s_axis_tdata_i[ReadingW+PosW:ReadingW+1];
      req.gap     = 0;
      advance_display(req);
      accepted_cnt++;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned total;
    int unsigned grp;
    int unsigned ticks;
    disp_digit[0] = BlankCode;
    disp_digit[1] = '0;
    disp_digit[2] = '0;
    disp_point    = PointReset;
    disp_scan     = '0;
    toggle_armed  = 1'b0;
    held_point    = PointUnits;

    // Directed: display after reset, a blank tick, largest shown value,
    // dropped readings including the most negative one, point handling.
    repeat (3) push_request(KindTick, '0, 1'b1, '0);
    push_request(KindTick, '0, 1'b0, '0);
    push_request(KindValue, ReadingW'(LimitTop - 1), 1'b0, '0);
    repeat (3) push_request(KindTick, '0, 1'b1, '0);
    push_request(KindValue, ReadingW'(-(32'd1 << (ReadingW - 1))), 1'b0, '0);
    push_request(KindValue, ReadingW'((32'd1 << (ReadingW - 1)) - 1), 1'b0, '0);
    push_request(KindValue, ReadingW'(-LimitTop), 1'b0, '0);
    push_request(KindTick, '0, 1'b1, '0);
    push_request(KindValue, ReadingW'(LimitMid - 1), 1'b0, '0);
    push_request(KindTick, '0, 1'b1, '0);
    push_request(KindSetPoint, '0, 1'b0, PointNone);
    push_request(KindTick, '0, 1'b1, '0);
    push_request(KindTogglePoint, '0, 1'b0, PointHund);
    push_request(KindTogglePoint, '0, 1'b0, PointNone);
    push_request(KindSetPoint, '0, 1'b0, 3'b100);
    push_request(KindTogglePoint, '0, 1'b0, PointNone);
    push_request(KindTogglePoint, '0, 1'b0, 3'd3);
    push_request(KindValue, ReadingW'(LimitHigh), 1'b0, '0);
    push_request(KindTick, '0, 1'b1, '0);
    push_request(KindValue, ReadingW'(-1), 1'b0, '0);
    push_request(KindTick, '0, 1'b1, '0);

    // Random: mostly a point change or value followed by a run of ticks,
    // with some bursts of arbitrary requests.
    while (request_q.size() < 1075) begin
      grp = $urandom_range(0, 19);
      if (grp < 13) begin
        push_request(KindValue, pick_reading(), 1'b0, '0);
      end else if (grp < 16) begin
        push_request(KindSetPoint, '0, 1'b0, PosW'($urandom));
      end else if (grp < 19) begin
        push_request(KindTogglePoint, '0, 1'b0,
                     $urandom_range(0, 1) ? PointNone : PosW'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          push_request(kind_e'($urandom_range(0, 3)), ReadingW'($urandom),
                       1'($urandom), PosW'($urandom));
      end
      ticks = $urandom_range(1, 6);
      repeat (ticks) push_request(KindTick, '0, $urandom_range(0, 5) != 0, '0);
    end
    total = request_q.size();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total) @(negedge clk_i);
    while (shown_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("PASS three_digit_seven_segment_scanner");
    end else begin
      $display("FAIL three_digit_seven_segment_scanner");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL three_digit_seven_segment_scanner");
    $finish;
  end

endmodule
